### rtl/smcg_pkg.sv
// Shared types and constants for the structured mesh connectivity generator.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package smcg_pkg;

  // Field widths
  localparam int unsigned AXIS_W  = 8;
  localparam int unsigned SHAPE_W = 3;
  localparam int unsigned CELL_W  = 27;
  localparam int unsigned VERT_W  = 24;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CIDX_W  = 2;

  // Largest grid size honored; larger register values saturate
  localparam int unsigned MAX_CELLS_PER_AXIS = 255;

  // (n+1)^2 for n up to 255, and z*(n+1)+y
  localparam int unsigned SQ_W  = 17;
  localparam int unsigned ROW_W = 16;

  // Command queue between front and back end
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Cell shape codes
  localparam logic [SHAPE_W-1:0] SHAPE_INTERVAL = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_QUAD     = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_TRI      = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_HEX      = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_TET      = 3'd4;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CELLS_PER_AXIS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CELL_SHAPE     = 2'd1;

  // One brick ready for expansion into cells
  typedef struct packed {
    logic [CELL_W-1:0]  cell_num;
    logic [SHAPE_W-1:0] shape;
    logic [AXIS_W-1:0]  n;
    logic [VERT_W-1:0]  base;
    logic [SQ_W-1:0]    sq;
    logic               done;
  } cmd_t;

  // One emitted cell
  typedef struct packed {
    logic [CELL_W-1:0]           cell_number;
    logic [7:0][VERT_W-1:0]      corners;
    logic [COUNT_W-1:0]          corner_count;
    logic                        brick_last;
    logic                        grid_done;
  } res_t;

endpackage

### rtl/smcg_front.sv
// Front end: configuration registers, brick walk state and base vertex pipeline.
// Accepts input items, decides whether a brick is emitted and issues commands.
// Depends on smcg_pkg.
module smcg_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_restart,
  output logic                          in_full,
  input  logic                          cfg_valid,
  input  logic [smcg_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [smcg_pkg::AXIS_W-1:0]   cfg_data,
  output logic                          cfg_ready,
  input  logic [smcg_pkg::QCNT_W-1:0]   q_count,
  output logic                          cmd_valid,
  output smcg_pkg::cmd_t                cmd
);

  typedef struct packed {
    logic [smcg_pkg::CELL_W-1:0]  cell_num;
    logic [smcg_pkg::SHAPE_W-1:0] shape;
    logic [smcg_pkg::AXIS_W-1:0]  n;
    logic [smcg_pkg::ROW_W-1:0]   row;
    logic [smcg_pkg::AXIS_W-1:0]  bx;
    logic [smcg_pkg::SQ_W-1:0]    sq;
    logic                         done;
  } stage1_t;

  localparam logic [9:0] MAX_N = 10'(smcg_pkg::MAX_CELLS_PER_AXIS);

  logic [smcg_pkg::AXIS_W-1:0]  n_cfg_r;
  logic [smcg_pkg::SHAPE_W-1:0] shape_r;

  logic [smcg_pkg::AXIS_W-1:0]  bx_r, by_r, bz_r, bx_nxt, by_nxt, bz_nxt;
  logic [smcg_pkg::CELL_W-1:0]  cnt_r, cnt_nxt;
  logic                         fin_r, fin_nxt;

  logic                         s1_v_r, s2_v_r;
  stage1_t                      s1_r;
  smcg_pkg::cmd_t               s2_r;

  logic [smcg_pkg::QCNT_W:0]    occ;
  logic                         accept, emit;
  logic [smcg_pkg::AXIS_W-1:0]  n, ebx, eby, ebz, n_m1;
  logic [smcg_pkg::CELL_W-1:0]  ecnt;
  logic                         efin;
  logic                         is1d, is3d, shape_ok, oob, last;
  logic [smcg_pkg::CELL_W-1:0]  ncells;
  logic [8:0]                   np1, s1_np1;
  logic [16:0]                  row_full;
  logic [17:0]                  sq_full;
  logic [24:0]                  base_full;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_cfg_r <= smcg_pkg::AXIS_W'(1);
      shape_r <= smcg_pkg::SHAPE_INTERVAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        smcg_pkg::CFG_CELLS_PER_AXIS: n_cfg_r <= cfg_data;
        smcg_pkg::CFG_CELL_SHAPE:     shape_r <= cfg_data[smcg_pkg::SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Reserve queue space for every command still in the pipeline
  assign occ     = (smcg_pkg::QCNT_W+1)'(q_count) + (smcg_pkg::QCNT_W+1)'(s1_v_r)
                 + (smcg_pkg::QCNT_W+1)'(s2_v_r);
  assign in_full = occ >= (smcg_pkg::QCNT_W+1)'(smcg_pkg::QDEPTH);
  assign accept  = in_push && !in_full;

  // Classify the item against the current walk state
  always_comb begin
    n    = (10'(n_cfg_r) > MAX_N) ? smcg_pkg::AXIS_W'(MAX_N) : n_cfg_r;
    n_m1 = n - smcg_pkg::AXIS_W'(1);
    ebx  = in_restart ? '0 : bx_r;
    eby  = in_restart ? '0 : by_r;
    ebz  = in_restart ? '0 : bz_r;
    ecnt = in_restart ? '0 : cnt_r;
    efin = in_restart ? 1'b0 : fin_r;

    is1d     = shape_r == smcg_pkg::SHAPE_INTERVAL;
    is3d     = shape_r == smcg_pkg::SHAPE_HEX || shape_r == smcg_pkg::SHAPE_TET;
    shape_ok = shape_r <= smcg_pkg::SHAPE_TET;

    oob = (n == '0) || (ebx >= n) ||
          (is1d ? (eby != '0) : (eby >= n)) ||
          (is3d ? (ebz >= n) : (ebz != '0));
    last = (ebx == n_m1) && (is1d || eby == n_m1) && (!is3d || ebz == n_m1);

    case (shape_r)
      smcg_pkg::SHAPE_TET: ncells = smcg_pkg::CELL_W'(6);
      smcg_pkg::SHAPE_TRI: ncells = smcg_pkg::CELL_W'(2);
      default:             ncells = smcg_pkg::CELL_W'(1);
    endcase

    emit = accept && shape_ok && !efin && !oob;

    bx_nxt  = bx_r;
    by_nxt  = by_r;
    bz_nxt  = bz_r;
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    if (accept) begin
      bx_nxt  = ebx;
      by_nxt  = eby;
      bz_nxt  = ebz;
      cnt_nxt = ecnt;
      fin_nxt = efin;
      if (shape_ok && !efin) begin
        if (oob) begin
          fin_nxt = 1'b1;
        end else begin
          cnt_nxt = ecnt + ncells;
          if (last) begin
            fin_nxt = 1'b1;
          end else if (ebx + smcg_pkg::AXIS_W'(1) >= n) begin
            bx_nxt = '0;
            if (eby + smcg_pkg::AXIS_W'(1) >= n) begin
              by_nxt = '0;
              bz_nxt = ebz + smcg_pkg::AXIS_W'(1);
            end else begin
              by_nxt = eby + smcg_pkg::AXIS_W'(1);
            end
          end else begin
            bx_nxt = ebx + smcg_pkg::AXIS_W'(1);
          end
        end
      end
    end
  end

  // Hold walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r  <= '0;
      by_r  <= '0;
      bz_r  <= '0;
      cnt_r <= '0;
      fin_r <= 1'b0;
    end else begin
      bx_r  <= bx_nxt;
      by_r  <= by_nxt;
      bz_r  <= bz_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
    end
  end

  // First multiply: row index z*(n+1)+y and plane size (n+1)^2
  assign np1      = 9'(n) + 9'd1;
  assign row_full = 17'(ebz) * 17'(np1) + 17'(eby);
  assign sq_full  = 18'(np1) * 18'(np1);

  // Second multiply: base vertex row*(n+1)+x, kept modulo 2^24
  assign s1_np1    = 9'(s1_r.n) + 9'd1;
  assign base_full = 25'(s1_r.row) * 25'(s1_np1) + 25'(s1_r.bx);

  // Advance the base vertex pipeline; queue space is already reserved
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= emit;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r.cell_num <= ecnt;
    s1_r.shape    <= shape_r;
    s1_r.n        <= n;
    s1_r.row      <= row_full[smcg_pkg::ROW_W-1:0];
    s1_r.bx       <= ebx;
    s1_r.sq       <= sq_full[smcg_pkg::SQ_W-1:0];
    s1_r.done     <= last;

    s2_r.cell_num <= s1_r.cell_num;
    s2_r.shape    <= s1_r.shape;
    s2_r.n        <= s1_r.n;
    s2_r.base     <= base_full[smcg_pkg::VERT_W-1:0];
    s2_r.sq       <= s1_r.sq;
    s2_r.done     <= s1_r.done;
  end

  assign cmd_valid = s2_v_r;
  assign cmd       = s2_r;

endmodule

### rtl/smcg_queue.sv
// Short command queue between the front end and the back end.
// Show-ahead FIFO of brick commands. Depends on smcg_pkg.
module smcg_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  smcg_pkg::cmd_t                push_data,
  input  logic                          pop,
  output smcg_pkg::cmd_t                head,
  output logic                          nonempty,
  output logic [smcg_pkg::QCNT_W-1:0]   count
);

  smcg_pkg::cmd_t                mem_r [smcg_pkg::QDEPTH];
  logic [smcg_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [smcg_pkg::QCNT_W-1:0]   cnt_r;
  logic                          do_pop;

  assign do_pop   = pop && (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign nonempty = cnt_r != '0;
  assign count    = cnt_r;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + smcg_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + smcg_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_r + smcg_pkg::QCNT_W'(push) - smcg_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

### rtl/smcg_back.sv
// Back end: expands brick commands into cells, one per cycle unless stalled.
// Holds the result register read by the output channel. Depends on smcg_pkg.
module smcg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  smcg_pkg::cmd_t   q_head,
  input  logic             q_nonempty,
  output logic             q_pop,
  input  logic             out_pop,
  output logic             out_empty,
  output smcg_pkg::res_t   res
);

  typedef struct packed {
    logic [7:0][2:0]               sel;
    logic [smcg_pkg::COUNT_W-1:0]  count;
  } layout_t;

  logic [2:0]      idx_r;
  logic            out_v_r;
  smcg_pkg::res_t  res_r, res_nxt;
  logic            advance, last_cell;
  logic [2:0]      last_idx;
  layout_t         lay;

  // Corner ordering of cell idx within a brick of the given shape
  function automatic layout_t cell_layout(input logic [smcg_pkg::SHAPE_W-1:0] shape,
                                          input logic [2:0] idx);
    layout_t l;
    l.sel   = '0;
    l.count = smcg_pkg::COUNT_W'(4);
    case (shape)
      smcg_pkg::SHAPE_INTERVAL: begin
        l.sel[1] = 3'd1;
        l.count  = smcg_pkg::COUNT_W'(2);
      end
      smcg_pkg::SHAPE_QUAD: begin
        l.sel[1] = 3'd1; l.sel[2] = 3'd3; l.sel[3] = 3'd2;
      end
      smcg_pkg::SHAPE_TRI: begin
        l.sel[1] = (idx == 3'd0) ? 3'd1 : 3'd2;
        l.sel[2] = 3'd3;
        l.count  = smcg_pkg::COUNT_W'(3);
      end
      smcg_pkg::SHAPE_HEX: begin
        l.sel[1] = 3'd1; l.sel[2] = 3'd3; l.sel[3] = 3'd2;
        l.sel[4] = 3'd4; l.sel[5] = 3'd5; l.sel[6] = 3'd7; l.sel[7] = 3'd6;
        l.count  = smcg_pkg::COUNT_W'(8);
      end
      default: begin
        case (idx)
          3'd0: begin l.sel[1] = 3'd1; l.sel[2] = 3'd3; l.sel[3] = 3'd7; end
          3'd1: begin l.sel[1] = 3'd1; l.sel[2] = 3'd7; l.sel[3] = 3'd5; end
          3'd2: begin l.sel[1] = 3'd5; l.sel[2] = 3'd7; l.sel[3] = 3'd4; end
          3'd3: begin l.sel[1] = 3'd3; l.sel[2] = 3'd2; l.sel[3] = 3'd7; end
          3'd4: begin l.sel[1] = 3'd6; l.sel[2] = 3'd4; l.sel[3] = 3'd7; end
          default: begin l.sel[1] = 3'd2; l.sel[2] = 3'd6; l.sel[3] = 3'd7; end
        endcase
      end
    endcase
    return l;
  endfunction

  // Offset of brick corner k from the base vertex
  function automatic logic [smcg_pkg::VERT_W-1:0] corner_offset(
      input logic [2:0] k,
      input logic [smcg_pkg::AXIS_W-1:0] n,
      input logic [smcg_pkg::SQ_W-1:0] sq);
    logic [smcg_pkg::VERT_W-1:0] np1, plane;
    np1   = smcg_pkg::VERT_W'(n) + smcg_pkg::VERT_W'(1);
    plane = smcg_pkg::VERT_W'(sq);
    case (k)
      3'd0:    return '0;
      3'd1:    return smcg_pkg::VERT_W'(1);
      3'd2:    return np1;
      3'd3:    return np1 + smcg_pkg::VERT_W'(1);
      3'd4:    return plane;
      3'd5:    return plane + smcg_pkg::VERT_W'(1);
      3'd6:    return plane + np1;
      default: return plane + np1 + smcg_pkg::VERT_W'(1);
    endcase
  endfunction

  // Pick the last cell index of the head brick
  always_comb begin
    case (q_head.shape)
      smcg_pkg::SHAPE_TET: last_idx = 3'd5;
      smcg_pkg::SHAPE_TRI: last_idx = 3'd1;
      default:             last_idx = 3'd0;
    endcase
  end

  assign advance   = q_nonempty && (!out_v_r || out_pop);
  assign last_cell = idx_r == last_idx;
  assign q_pop     = advance && last_cell;
  assign lay       = cell_layout(q_head.shape, idx_r);

  // Build the next cell
  always_comb begin
    res_nxt.cell_number  = q_head.cell_num + smcg_pkg::CELL_W'(idx_r);
    res_nxt.corner_count = lay.count;
    res_nxt.brick_last   = last_cell;
    res_nxt.grid_done    = q_head.done;
    for (int c = 0; c < 8; c++) begin
      if (smcg_pkg::COUNT_W'(c) < lay.count) begin
        res_nxt.corners[c] = q_head.base + corner_offset(lay.sel[c], q_head.n, q_head.sq);
      end else begin
        res_nxt.corners[c] = '0;
      end
    end
  end

  // Step through the cells of the head brick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r   <= last_cell ? 3'd0 : idx_r + 3'd1;
        out_v_r <= 1'b1;
      end else if (out_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_empty = !out_v_r;
  assign res       = res_r;

endmodule

### rtl/structured_mesh_connectivity_gen.sv
// Structured grid cell connectivity generator, top level.
// Instantiates smcg_front, smcg_queue and smcg_back; depends on smcg_pkg.
//
// Usage:
//   Input channel (in_push / in_full, payload in_restart): each transfer steps
//   the walk by one brick, x fastest, then y, then z. in_restart = 1 returns to
//   brick zero and cell number zero first. Once the last brick is out, items
//   give no cells until a restart.
//   Result channel (out_empty / out_pop): one cell per transfer, with its global
//   number, up to eight vertex indices (unused ones zero), corner count, a
//   last-cell-of-brick flag and a final-brick flag.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 sets
//   cells per axis, index 1 the cell shape. cfg_ready is always high.
// Flow:
//   The first cell of a brick passes the first multiply stage, the second
//   multiply stage, the queue write and the result register in that order;
//   the result register waits while the receiver stalls.
//   The back end sends one cell per cycle while the receiver keeps up, and a
//   brick gives one cell for interval, quad and hex shapes, two for triangles
//   and six for tetrahedra. A four-entry command queue decouples the two ends.
//   When the receiver stalls, the queue fills and in_full rises; nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue and result register,
//   restores cells per axis 1 and the interval shape, and rewinds the walk.
module structured_mesh_connectivity_gen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_restart,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [smcg_pkg::CELL_W-1:0]   out_cell_number,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_a,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_b,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_c,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_d,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_e,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_f,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_g,
  output logic [smcg_pkg::VERT_W-1:0]   out_corner_h,
  output logic [smcg_pkg::COUNT_W-1:0]  out_corner_count,
  output logic                          out_brick_last,
  output logic                          out_grid_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smcg_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [smcg_pkg::AXIS_W-1:0]   cfg_data
);

  logic                          cmd_valid;
  smcg_pkg::cmd_t                cmd;
  smcg_pkg::cmd_t                q_head;
  logic                          q_nonempty, q_pop;
  logic [smcg_pkg::QCNT_W-1:0]   q_count;
  smcg_pkg::res_t                res;

  smcg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_restart (in_restart),
    .in_full    (in_full),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .q_count    (q_count),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  smcg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_valid),
    .push_data (cmd),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty),
    .count     (q_count)
  );

  smcg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_nonempty (q_nonempty),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .res        (res)
  );

  // Unpack the result register onto the ports
  assign out_cell_number  = res.cell_number;
  assign out_corner_a     = res.corners[0];
  assign out_corner_b     = res.corners[1];
  assign out_corner_c     = res.corners[2];
  assign out_corner_d     = res.corners[3];
  assign out_corner_e     = res.corners[4];
  assign out_corner_f     = res.corners[5];
  assign out_corner_g     = res.corners[6];
  assign out_corner_h     = res.corners[7];
  assign out_corner_count = res.corner_count;
  assign out_brick_last   = res.brick_last;
  assign out_grid_done    = res.grid_done;

`ifndef SYNTHESIS
  // Reserved space means a command never meets a full queue
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> (q_count < smcg_pkg::QCNT_W'(smcg_pkg::QDEPTH)))
    else $error("command pushed into a full queue");

  // Only triangle and tetrahedron bricks have more than one cell
  a_multi_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_brick_last) |->
      (out_corner_count == smcg_pkg::COUNT_W'(3) ||
       out_corner_count == smcg_pkg::COUNT_W'(4)))
    else $error("non-final cell from a single-cell shape");

  // Corner count is one of the supported shapes
  a_corner_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |->
      (out_corner_count == smcg_pkg::COUNT_W'(2) ||
       out_corner_count == smcg_pkg::COUNT_W'(3) ||
       out_corner_count == smcg_pkg::COUNT_W'(4) ||
       out_corner_count == smcg_pkg::COUNT_W'(8)))
    else $error("bad corner count");

  // The queue is popped only when a command is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty)
    else $error("queue popped while empty");
`endif

endmodule
